// ----- hw/rtl/edd_pkg.sv -----
// shared types and constants for the error diffusion dither block
// used by edd_ctrl, edd_datapath and error_diffusion_dither_top; no dependencies

package edd_pkg;

  // geometry and number format
  localparam int MAX_WIDTH     = 1024;
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int FILL_W        = COL_W + 1;
  localparam int FRACTION_BITS = 8;
  localparam int ERR_W         = FRACTION_BITS + 10;
  localparam int RND_W         = ERR_W + 1 - FRACTION_BITS;
  localparam int WIDE_W        = ERR_W + 5;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int LWIDTH_W   = 11;
  localparam int LEVELS_W   = 9;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS     = 1'd1;

  localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RST = 11'd256;
  localparam logic [LEVELS_W-1:0] LEVELS_RST     = 9'd16;

  // reciprocal precision for the divide by step
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_QUOT,
    ST_IDX,
    ST_ERR,
    ST_WR,
    ST_OUT
  } edd_state_t;

  typedef struct packed {
    logic accept;
    logic sum_en;
    logic quot_en;
    logic idx_en;
    logic err_en;
    logic wr_en;
    logic fin_en;
    logic load_out;
  } edd_cmd_t;

  typedef struct packed {
    logic out_free;
  } edd_status_t;

endpackage

// ----- hw/rtl/error_diffusion_dither_top.sv -----
// top level of the floyd-steinberg error diffusion dither block
// joins edd_ctrl and edd_datapath; depends on edd_pkg
//
//   channel  direction  transaction carries
//   in_*     sink       one grey pixel and its frame start mark
//   out_*    source     quantized value, level index and row end
//   cfg_*    sink       one write of line_width (index 0) or levels (index 1)
//
// the accepting edge also reads the line store; the pixel then passes the steps
// (sum and round, reciprocal multiply, index and level multiply, error weighting,
// store write, output load) and the next pixel is taken only after the output load,
// so pixels are handled one at a time
// the output step stalls while a result waits in the output register and out_tready
// is low; the next pixel is taken while a finished result still waits there
// reset (rst_n low, synchronous) restores line_width 256 and levels 16 and clears
// the carries; the line store needs no clearing pass, a fill count marks live entries

module error_diffusion_dither_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] pixel
  input  logic                            in_tuser,   // [0] frame_start
  // result output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [7:0] quantized_value, [15:8] level_index
  output logic                            out_tlast,  // row_end
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [edd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [edd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import edd_pkg::*;

  edd_cmd_t    cmd;
  edd_status_t status;
  logic [7:0]  out_qval;
  logic [7:0]  out_level;

  // configuration is always taken; the user must write it only while the block is idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  edd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  edd_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .pixel       (in_tdata),
    .frame_start (in_tuser),
    .cfg_we      (cfg_valid),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_qval    (out_qval),
    .out_level   (out_level),
    .out_last    (out_tlast)
  );

  // result packing, first field in the low byte
  assign out_tdata = {out_level, out_qval};

endmodule

// ----- hw/rtl/edd_ctrl.sv -----
// sequencer for the error diffusion dither block
// walks one pixel through the datapath steps; depends on edd_pkg

module edd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  edd_pkg::edd_status_t status,
  output edd_pkg::edd_cmd_t    cmd
);
  import edd_pkg::*;

  edd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_QUOT;
      end
      ST_QUOT: begin
        cmd.quot_en = 1'b1;
        state_nxt   = ST_IDX;
      end
      ST_IDX: begin
        cmd.idx_en = 1'b1;
        state_nxt  = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_en = 1'b1;
        state_nxt  = ST_WR;
      end
      ST_WR: begin
        cmd.wr_en = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // row-end write repeats harmlessly while the output register is full
        cmd.fin_en = 1'b1;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/edd_datapath.sv -----
// datapath of the error diffusion dither block: config registers, line store,
// quantizer, error weighting and output register; depends on edd_pkg

module edd_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  edd_pkg::edd_cmd_t                   cmd,
  output edd_pkg::edd_status_t                status,
  input  logic [7:0]                          pixel,
  input  logic                                frame_start,
  input  logic                                cfg_we,
  input  logic [edd_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [edd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [7:0]                          out_qval,
  output logic [7:0]                          out_level,
  output logic                                out_last
);
  import edd_pkg::*;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((1 <<< (ERR_W - 1)) - 1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) return ERR_W'(hi);
    if (v < lo) return ERR_W'(lo);
    return ERR_W'(v);
  endfunction

  function automatic logic signed [ERR_W-1:0] weigh(input logic signed [ERR_W:0] e,
                                                    input logic signed [WIDE_W-1:0] w);
    logic signed [WIDE_W-1:0] t;
    t = WIDE_W'(e) * w + WIDE_W'(8);
    return sat_err(t >>> 4);
  endfunction

  // configuration
  logic [LWIDTH_W-1:0] line_width_r;
  logic [LEVELS_W-1:0] levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      levels_r     <= LEVELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LINE_WIDTH: line_width_r <= cfg_wdata[LWIDTH_W-1:0];
        REG_LEVELS:     levels_r     <= cfg_wdata[LEVELS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LWIDTH_W-1:0] width_sat;
  logic [LEVELS_W-1:0] levels_sat;

  always_comb begin
    width_sat = line_width_r;
    if (line_width_r == '0) width_sat = LWIDTH_W'(1);
    if (line_width_r > LWIDTH_W'(MAX_WIDTH)) width_sat = LWIDTH_W'(MAX_WIDTH);
    levels_sat = levels_r;
    if (levels_r < LEVELS_W'(2)) levels_sat = LEVELS_W'(2);
    if (levels_r > LEVELS_W'(256)) levels_sat = LEVELS_W'(256);
  end

  // step and reciprocal tables, one entry per level count
  logic [7:0]         step_tab  [2:256];
  logic [RECIP_W-1:0] recip_tab [2:256];

  for (genvar g = 2; g <= 256; g++) begin : g_tab
    localparam int StepG  = 256 / g;
    localparam int RecipG = ((1 << RECIP_SHIFT) + StepG - 1) / StepG;
    assign step_tab[g]  = 8'(StepG);
    assign recip_tab[g] = RECIP_W'(RecipG);
  end

  logic [7:0]         step_r;
  logic [RECIP_W-1:0] recip_r;
  logic [7:0]         lvm1_r;

  always_ff @(posedge clk) begin
    step_r  <= step_tab[levels_sat];
    recip_r <= recip_tab[levels_sat];
    lvm1_r  <= 8'(levels_sat - LEVELS_W'(1));
  end

  // line store
  logic signed [ERR_W-1:0] mem [MAX_WIDTH];
  logic signed [ERR_W-1:0] rd_data_r;
  logic [COL_W-1:0]        rd_addr;
  logic                    mem_we;
  logic [COL_W-1:0]        mem_wa;
  logic signed [ERR_W-1:0] mem_wd;

  // row state
  logic [COL_W-1:0]        column_r;
  logic [FILL_W-1:0]       fill_r;
  logic signed [ERR_W-1:0] rc_r;
  logic signed [ERR_W-1:0] pbl_r;
  logic signed [ERR_W-1:0] pb_r;

  // per-pixel working registers
  logic [7:0]              pix_r;
  logic [COL_W-1:0]        col_r;
  logic                    rd_ok_r;
  logic                    last_r;
  logic signed [ERR_W-1:0] sum_r;
  logic signed [RND_W-1:0] rnd_r;
  logic [RECIP_W+7:0]      prod_r;
  logic                    neg_r;
  logic                    big_r;
  logic [7:0]              idx_r;
  logic [7:0]              qv_r;
  logic signed [ERR_W-1:0] e7_r, e3_r, e5_r, e1_r;
  logic signed [ERR_W-1:0] cur_r;

  assign rd_addr = frame_start ? '0 : column_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  // sum, rounding
  logic signed [WIDE_W-1:0] sum_w;
  logic signed [ERR_W-1:0]  sum_s;
  logic signed [ERR_W:0]    sum_rb;
  logic signed [ERR_W-1:0]  below_val;

  always_comb begin
    below_val = rd_ok_r ? rd_data_r : '0;
    sum_w  = WIDE_W'($signed({1'b0, pix_r, FRACTION_BITS'(0)})) + WIDE_W'(rc_r)
           + WIDE_W'(below_val);
    sum_s  = sat_err(sum_w);
    sum_rb = (ERR_W + 1)'(sum_s) + (ERR_W + 1)'(1 <<< (FRACTION_BITS - 1));
  end

  // index
  logic [7:0] q_val;
  logic [7:0] idx_c;

  always_comb begin
    q_val = prod_r[RECIP_SHIFT+7:RECIP_SHIFT];
    if (neg_r) idx_c = '0;
    else if (big_r) idx_c = lvm1_r;
    else idx_c = q_val;
    if (idx_c > lvm1_r) idx_c = lvm1_r;
  end

  // error
  logic signed [ERR_W:0]   err_c;
  logic signed [ERR_W-1:0] bl_c;
  logic signed [ERR_W-1:0] cur_c;

  always_comb begin
    err_c = (ERR_W + 1)'(sum_r) - (ERR_W + 1)'($signed({1'b0, qv_r, FRACTION_BITS'(0)}));
    bl_c  = sat_err(WIDE_W'(pbl_r) + WIDE_W'(e3_r));
    cur_c = sat_err(WIDE_W'(pb_r) + WIDE_W'(e5_r));
  end

  // write port: left neighbour below in the write step, own column on row end
  always_comb begin
    mem_we = 1'b0;
    mem_wa = col_r - COL_W'(1);
    mem_wd = bl_c;
    if (cmd.wr_en && (col_r != '0)) begin
      mem_we = 1'b1;
    end else if (cmd.fin_en && last_r) begin
      mem_we = 1'b1;
      mem_wa = col_r;
      mem_wd = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r   <= pixel;
      col_r   <= rd_addr;
      rd_ok_r <= !frame_start && ({1'b0, column_r} < fill_r);
      last_r  <= ((LWIDTH_W'(rd_addr) + LWIDTH_W'(1)) >= width_sat);
    end
    if (cmd.sum_en) begin
      sum_r <= sum_s;
      rnd_r <= RND_W'(sum_rb >>> FRACTION_BITS);
    end
    if (cmd.quot_en) begin
      prod_r <= rnd_r[7:0] * recip_r;
      neg_r  <= rnd_r[RND_W-1];
      big_r  <= !rnd_r[RND_W-1] && (rnd_r[RND_W-2:8] != '0);
    end
    if (cmd.idx_en) begin
      idx_r <= idx_c;
      qv_r  <= 8'(idx_c * step_r);
    end
    if (cmd.err_en) begin
      e7_r <= weigh(err_c, WIDE_W'(7));
      e3_r <= weigh(err_c, WIDE_W'(3));
      e5_r <= weigh(err_c, WIDE_W'(5));
      e1_r <= weigh(err_c, WIDE_W'(1));
    end
    if (cmd.wr_en) begin
      cur_r <= cur_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      fill_r   <= '0;
      rc_r     <= '0;
      pbl_r    <= '0;
      pb_r     <= '0;
    end else begin
      if (cmd.accept && frame_start) begin
        column_r <= '0;
        fill_r   <= '0;
        rc_r     <= '0;
        pbl_r    <= '0;
        pb_r     <= '0;
      end
      if (cmd.wr_en) begin
        if (last_r) begin
          column_r <= '0;
          rc_r     <= '0;
          pbl_r    <= '0;
          pb_r     <= '0;
        end else begin
          column_r <= col_r + COL_W'(1);
          rc_r     <= e7_r;
          pbl_r    <= cur_c;
          pb_r     <= e1_r;
        end
      end
      // written entries always form a prefix of the row
      if (mem_we && ((FILL_W'(mem_wa) + FILL_W'(1)) > fill_r)) begin
        fill_r <= FILL_W'(mem_wa) + FILL_W'(1);
      end
    end
  end

  // output register
  logic out_valid_r;
  logic [7:0] out_qval_r;
  logic [7:0] out_level_r;
  logic out_last_r;

  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_qval_r  <= qv_r;
      out_level_r <= idx_r;
      out_last_r  <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_qval   = out_qval_r;
  assign out_level  = out_level_r;
  assign out_last   = out_last_r;

endmodule
